/* rtl/core/bts_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bts_pkg;

  localparam int CFG_W   = 9;   // width of the size registers
  localparam int ADDR_W  = 16;  // texel address width
  localparam int CH_W    = 8;   // bits per color channel
  localparam int NUM_CH  = 4;   // red, green, blue, alpha
  localparam int TEXEL_W = CH_W * NUM_CH;
  localparam int COORD_W = 18;  // signed Q1.16 input coordinate
  localparam int UC_W    = 17;  // clamped coordinate, 0 .. 1.0
  localparam int FRAC_W  = 8;   // filter weight bits
  localparam int OUT_W   = 16;  // Q8.8 result channel
  localparam int CFG_IDX_W = 2;

  localparam logic [UC_W-1:0] ONE_Q16 = UC_W'(65536);
  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(256);

  typedef enum logic {
    MODE_WRITE  = 1'b0,
    MODE_SAMPLE = 1'b1
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef logic [TEXEL_W-1:0] texel_t;

  // Clamp a signed Q1.16 coordinate to the range 0 .. 1.0.
  function automatic logic [UC_W-1:0] clamp_coord(input logic [COORD_W-1:0] raw);
    logic [UC_W-1:0] mag;
    mag = raw[UC_W-1:0];
    if (raw[COORD_W-1]) begin
      return '0;
    end else if (mag > ONE_Q16) begin
      return ONE_Q16;
    end
    return mag;
  endfunction

  // Exact lerp of two 8-bit channels with an 8-bit weight: a*(256-f) + b*f,
  // written as a*256 + (b-a)*f so that it needs one multiplier.
  function automatic logic [OUT_W-1:0] lerp_h(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b,
                                               input logic [FRAC_W-1:0] f);
    logic signed [CH_W:0]       diff;
    logic signed [2*CH_W+1:0]   prod;
    logic signed [2*CH_W+1:0]   sum;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = diff * $signed({1'b0, f});
    sum  = $signed({2'b00, a, {FRAC_W{1'b0}}}) + prod;
    return sum[OUT_W-1:0];
  endfunction

  // Vertical lerp of two Q8.8 values, floored back to Q8.8.
  function automatic logic [OUT_W-1:0] lerp_v(input logic [OUT_W-1:0] lo,
                                               input logic [OUT_W-1:0] hi,
                                               input logic [FRAC_W-1:0] f);
    logic signed [OUT_W:0]          diff;
    logic signed [OUT_W+FRAC_W+1:0] prod;
    logic signed [OUT_W+FRAC_W+1:0] sum;
    diff = $signed({1'b0, hi}) - $signed({1'b0, lo});
    prod = diff * $signed({1'b0, f});
    sum  = $signed({2'b00, lo, {FRAC_W{1'b0}}}) + prod;
    return sum[OUT_W+FRAC_W-1:FRAC_W];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/bilinear_texture_sampler.sv */
`timescale 1ns / 1ps
`default_nettype none

// Throughput: one request per clock, writes and samples alike, stalled only by reset.
// A sample raises its result strobe from the stage 6 output registers after passing
// every earlier stage. A write reaches the texel memory from the stage 3 registers and is
// seen by any later sample.
// Reset clears the pipeline valid bits and sets both size registers to 256; the texel
// memory is not cleared. The receiver cannot stall, so the pipeline never holds.
module bilinear_texture_sampler #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Request channel
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              in_mode,
  input  wire logic [bts_pkg::ADDR_W-1:0]        in_texel_addr,
  input  wire logic [bts_pkg::CH_W-1:0]          in_texel_red,
  input  wire logic [bts_pkg::CH_W-1:0]          in_texel_green,
  input  wire logic [bts_pkg::CH_W-1:0]          in_texel_blue,
  input  wire logic [bts_pkg::CH_W-1:0]          in_texel_alpha,
  input  wire logic signed [bts_pkg::COORD_W-1:0] in_u_coord,
  input  wire logic signed [bts_pkg::COORD_W-1:0] in_v_coord,
  // Result channel
  output logic                                   out_valid,
  output logic [bts_pkg::OUT_W-1:0]              out_red,
  output logic [bts_pkg::OUT_W-1:0]              out_green,
  output logic [bts_pkg::OUT_W-1:0]              out_blue,
  output logic [bts_pkg::OUT_W-1:0]              out_alpha,
  // Configuration channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bts_pkg::CFG_W-1:0]         cfg_data
);

  import bts_pkg::*;

  // The size registers are 9 bits wide, so the usable size never exceeds 511 even when
  // the maximum parameter is larger. Column and row indexes are sized from that limit.
  localparam int W_LIM = (MAX_WIDTH  < 511) ? MAX_WIDTH  : 511;
  localparam int H_LIM = (MAX_HEIGHT < 511) ? MAX_HEIGHT : 511;
  localparam int XW    = $clog2(W_LIM);      // column index bits
  localparam int YH    = $clog2(H_LIM);      // row index bits
  localparam int WW    = $clog2(W_LIM + 1);  // width value bits
  localparam int HW    = $clog2(H_LIM + 1);  // height value bits
  localparam int MEM_DEPTH = 1 << ADDR_W;

  // ---------------------------------------------------------------------------
  // Handshakes. The pipeline runs freely, so a request is taken in every cycle
  // outside of reset, and so is a configuration write.
  // ---------------------------------------------------------------------------
  logic in_fire;

  assign busy      = ~rst_n;
  assign cfg_ready = rst_n;
  assign in_fire   = start & ~busy;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes must arrive only while the pipeline is empty; the
  // user ensures it, the block does not. So every stage reads the current sizes directly.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] width_r, width_nxt;
  logic [CFG_W-1:0] height_r, height_nxt;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  width_nxt  = cfg_data;
        CFG_IMAGE_HEIGHT: height_nxt = cfg_data;
        default: ;  // writes to unknown registers are dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_RESET;
      height_r <= SIZE_RESET;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // Effective sizes: a zero size acts as one, and a size above the maximum saturates.
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [XW-1:0] w_m1;
  logic [YH-1:0] h_m1;

  always_comb begin
    if (width_r == '0) begin
      eff_w = WW'(1);
    end else if (width_r > CFG_W'(W_LIM)) begin
      eff_w = WW'(W_LIM);
    end else begin
      eff_w = WW'(width_r);
    end
    if (height_r == '0) begin
      eff_h = HW'(1);
    end else if (height_r > CFG_W'(H_LIM)) begin
      eff_h = HW'(H_LIM);
    end else begin
      eff_h = HW'(height_r);
    end
    w_m1 = XW'(eff_w - WW'(1));
    h_m1 = YH'(eff_h - HW'(1));
  end

  // ---------------------------------------------------------------------------
  // Stage 1: register the request with both coordinates clamped to 0 .. 1.0.
  // ---------------------------------------------------------------------------
  logic              s1_vld_r;
  logic              s1_mode_r;
  logic [ADDR_W-1:0] s1_addr_r;
  texel_t            s1_data_r;
  logic [UC_W-1:0]   s1_u_r;
  logic [UC_W-1:0]   s1_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    s1_mode_r <= in_mode;
    s1_addr_r <= in_texel_addr;
    s1_data_r <= {in_texel_alpha, in_texel_blue, in_texel_green, in_texel_red};
    s1_u_r    <= clamp_coord(in_u_coord);
    s1_v_r    <= clamp_coord(in_v_coord);
  end

  // ---------------------------------------------------------------------------
  // Stage 2: scale the coordinates by size minus one. The integer part selects
  // the texel, the next eight bits below the binary point are the weight.
  // ---------------------------------------------------------------------------
  logic [UC_W+XW-1:0] px;
  logic [UC_W+YH-1:0] py;

  logic              s2_vld_r;
  logic              s2_mode_r;
  logic [ADDR_W-1:0] s2_addr_r;
  texel_t            s2_data_r;
  logic [XW-1:0]     s2_cx_r;
  logic [YH-1:0]     s2_cy_r;
  logic [FRAC_W-1:0] s2_fx_r;
  logic [FRAC_W-1:0] s2_fy_r;

  assign px = s1_u_r * w_m1;
  assign py = s1_v_r * h_m1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_mode_r <= s1_mode_r;
    s2_addr_r <= s1_addr_r;
    s2_data_r <= s1_data_r;
    s2_cx_r   <= px[UC_W-1 +: XW];
    s2_cy_r   <= py[UC_W-1 +: YH];
    s2_fx_r   <= px[UC_W-2 -: FRAC_W];
    s2_fy_r   <= py[UC_W-2 -: FRAC_W];
  end

  // ---------------------------------------------------------------------------
  // Stage 3: find the neighbor column and row, clamped to the last one, and
  // compute the two row base addresses.
  // ---------------------------------------------------------------------------
  logic [XW:0]        cx_inc;
  logic [YH:0]        cy_inc;
  logic [XW-1:0]      cx1;
  logic [YH-1:0]      cy1;
  logic [YH+WW-1:0]   row0_full;
  logic [YH+WW-1:0]   row1_full;

  logic              s3_vld_r;
  logic              s3_mode_r;
  logic [ADDR_W-1:0] s3_addr_r;
  texel_t            s3_data_r;
  logic [XW-1:0]     s3_cx_r;
  logic [XW-1:0]     s3_cx1_r;
  logic [ADDR_W-1:0] s3_row0_r;
  logic [ADDR_W-1:0] s3_row1_r;
  logic [FRAC_W-1:0] s3_fx_r;
  logic [FRAC_W-1:0] s3_fy_r;

  always_comb begin
    cx_inc = {1'b0, s2_cx_r} + (XW+1)'(1);
    cy_inc = {1'b0, s2_cy_r} + (YH+1)'(1);
    cx1    = (cx_inc < {1'b0, w_m1}) ? cx_inc[XW-1:0] : w_m1;
    cy1    = (cy_inc < {1'b0, h_m1}) ? cy_inc[YH-1:0] : h_m1;
    row0_full = s2_cy_r * eff_w;
    row1_full = cy1 * eff_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_mode_r <= s2_mode_r;
    s3_addr_r <= s2_addr_r;
    s3_data_r <= s2_data_r;
    s3_cx_r   <= s2_cx_r;
    s3_cx1_r  <= cx1;
    s3_row0_r <= ADDR_W'(row0_full);
    s3_row1_r <= ADDR_W'(row1_full);
    s3_fx_r   <= s2_fx_r;
    s3_fy_r   <= s2_fy_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 4: texel memory. Two identical copies are kept, each written by every
  // texel write and each read at two addresses: the upper row pair comes from
  // one copy, the lower pair from the other. Writes and reads happen in the
  // same stage, so a sample always sees every write that came before it.
  // ---------------------------------------------------------------------------
  texel_t mem_top [0:MEM_DEPTH-1];
  texel_t mem_bot [0:MEM_DEPTH-1];

  logic [ADDR_W-1:0] a00, a10, a01, a11;
  logic              mem_wr;

  assign a00    = s3_row0_r + ADDR_W'(s3_cx_r);
  assign a10    = s3_row0_r + ADDR_W'(s3_cx1_r);
  assign a01    = s3_row1_r + ADDR_W'(s3_cx_r);
  assign a11    = s3_row1_r + ADDR_W'(s3_cx1_r);
  assign mem_wr = s3_vld_r && (s3_mode_r == MODE_WRITE);

  logic              s4_vld_r;
  texel_t            s4_t00_r, s4_t10_r, s4_t01_r, s4_t11_r;
  logic [FRAC_W-1:0] s4_fx_r;
  logic [FRAC_W-1:0] s4_fy_r;

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem_top[s3_addr_r] <= s3_data_r;
      mem_bot[s3_addr_r] <= s3_data_r;
    end
    s4_t00_r <= mem_top[a00];
    s4_t10_r <= mem_top[a10];
    s4_t01_r <= mem_bot[a01];
    s4_t11_r <= mem_bot[a11];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r && (s3_mode_r == MODE_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    s4_fx_r <= s3_fx_r;
    s4_fy_r <= s3_fy_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 5: horizontal lerp of both rows, exact in Q8.8.
  // ---------------------------------------------------------------------------
  logic [OUT_W-1:0] lo_nxt [NUM_CH];
  logic [OUT_W-1:0] hi_nxt [NUM_CH];

  logic              s5_vld_r;
  logic [OUT_W-1:0]  s5_lo_r [NUM_CH];
  logic [OUT_W-1:0]  s5_hi_r [NUM_CH];
  logic [FRAC_W-1:0] s5_fy_r;

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      lo_nxt[ch] = lerp_h(s4_t00_r[CH_W*ch +: CH_W], s4_t10_r[CH_W*ch +: CH_W], s4_fx_r);
      hi_nxt[ch] = lerp_h(s4_t01_r[CH_W*ch +: CH_W], s4_t11_r[CH_W*ch +: CH_W], s4_fx_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s5_lo_r <= lo_nxt;
    s5_hi_r <= hi_nxt;
    s5_fy_r <= s4_fy_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 6: vertical lerp, floored to Q8.8, into the output registers.
  // ---------------------------------------------------------------------------
  logic [OUT_W-1:0] res_nxt [NUM_CH];
  logic             out_valid_r;
  logic [OUT_W-1:0] out_ch_r [NUM_CH];

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      res_nxt[ch] = lerp_v(s5_lo_r[ch], s5_hi_r[ch], s5_fy_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_ch_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_ch_r[0];
  assign out_green = out_ch_r[1];
  assign out_blue  = out_ch_r[2];
  assign out_alpha = out_ch_r[3];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // Every accepted sample request produces a result strobe.
  a_sample_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_mode == MODE_SAMPLE) |-> ##6 out_valid)
    else $error("sample request did not produce a result");

  // A texel write never produces a result.
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_mode == MODE_WRITE) |-> ##6 !out_valid)
    else $error("texel write produced a result");

  // The neighbor column is the same column or the one after it.
  a_neighbor: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_vld_r && s3_mode_r == MODE_SAMPLE) |->
      (s3_cx1_r == s3_cx_r || {1'b0, s3_cx1_r} == {1'b0, s3_cx_r} + (XW+1)'(1)))
    else $error("neighbor column out of step");

  // No result strobes right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe following reset");

endmodule

`default_nettype wire

/* tb/sampler_checker.sv */
`timescale 1ns / 1ps

// Watches the request, result and register channels of the sampler, keeps its
// own copy of the texture and the size registers, and predicts every filtered
// result at the moment its sample request is accepted.
module sampler_checker #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  input  wire logic                                 busy,
  input  wire logic                                 in_mode,
  input  wire logic [bts_pkg::ADDR_W-1:0]           in_texel_addr,
  input  wire logic [bts_pkg::CH_W-1:0]             in_texel_red,
  input  wire logic [bts_pkg::CH_W-1:0]             in_texel_green,
  input  wire logic [bts_pkg::CH_W-1:0]             in_texel_blue,
  input  wire logic [bts_pkg::CH_W-1:0]             in_texel_alpha,
  input  wire logic signed [bts_pkg::COORD_W-1:0]   in_u_coord,
  input  wire logic signed [bts_pkg::COORD_W-1:0]   in_v_coord,
  input  wire logic                                 out_valid,
  input  wire logic [bts_pkg::OUT_W-1:0]            out_red,
  input  wire logic [bts_pkg::OUT_W-1:0]            out_green,
  input  wire logic [bts_pkg::OUT_W-1:0]            out_blue,
  input  wire logic [bts_pkg::OUT_W-1:0]            out_alpha,
  input  wire logic                                 cfg_valid,
  input  wire logic                                 cfg_ready,
  input  wire logic [bts_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [bts_pkg::CFG_W-1:0]            cfg_data,
  output int                                        mismatches,
  output int                                        samples_in_flight
);

  typedef struct packed {
    logic [bts_pkg::OUT_W-1:0] red;
    logic [bts_pkg::OUT_W-1:0] green;
    logic [bts_pkg::OUT_W-1:0] blue;
    logic [bts_pkg::OUT_W-1:0] alpha;
  } filtered_t;

  logic [bts_pkg::TEXEL_W-1:0] texture [0:65535];
  logic [bts_pkg::CFG_W-1:0]   width_reg;
  logic [bts_pkg::CFG_W-1:0]   height_reg;
  filtered_t                   filtered_q [$];

  function automatic int unsigned usable_size(input logic [bts_pkg::CFG_W-1:0] size_reg,
                                              input int unsigned limit);
    if (size_reg == '0) begin
      return 1;
    end
    return (size_reg > limit) ? limit : size_reg;
  endfunction

  function automatic logic [bts_pkg::UC_W-1:0] unit_range(
      input logic signed [bts_pkg::COORD_W-1:0] c);
    if (c < 0) begin
      return '0;
    end else if (c > 65536) begin
      return bts_pkg::UC_W'(65536);
    end
    return c[bts_pkg::UC_W-1:0];
  endfunction

  // Exact horizontal blends of both rows, then a floored vertical blend.
  function automatic logic [bts_pkg::OUT_W-1:0] blend_channel(
      input logic [bts_pkg::CH_W-1:0] top_l, input logic [bts_pkg::CH_W-1:0] top_r,
      input logic [bts_pkg::CH_W-1:0] bot_l, input logic [bts_pkg::CH_W-1:0] bot_r,
      input int unsigned fx, input int unsigned fy);
    int unsigned upper;
    int unsigned lower;
    upper = top_l * (256 - fx) + top_r * fx;
    lower = bot_l * (256 - fx) + bot_r * fx;
    return bts_pkg::OUT_W'((upper * (256 - fy) + lower * fy) >> 8);
  endfunction

  function automatic filtered_t bilinear_filter(input logic signed [bts_pkg::COORD_W-1:0] u,
                                                input logic signed [bts_pkg::COORD_W-1:0] v);
    int unsigned w, h, px, py, cx, cy, cx1, cy1, fx, fy;
    logic [bts_pkg::TEXEL_W-1:0] t00, t10, t01, t11;
    filtered_t res;
    w   = usable_size(width_reg, MAX_WIDTH);
    h   = usable_size(height_reg, MAX_HEIGHT);
    px  = unit_range(u) * (w - 1);
    py  = unit_range(v) * (h - 1);
    cx  = px >> 16;
    cy  = py >> 16;
    fx  = (px >> 8) & 255;
    fy  = (py >> 8) & 255;
    cx1 = (cx + 1 < w - 1) ? cx + 1 : w - 1;
    cy1 = (cy + 1 < h - 1) ? cy + 1 : h - 1;
    t00 = texture[bts_pkg::ADDR_W'(cx + cy * w)];
    t10 = texture[bts_pkg::ADDR_W'(cx1 + cy * w)];
    t01 = texture[bts_pkg::ADDR_W'(cx + cy1 * w)];
    t11 = texture[bts_pkg::ADDR_W'(cx1 + cy1 * w)];
    res.red   = blend_channel(t00[7:0], t10[7:0], t01[7:0], t11[7:0], fx, fy);
    res.green = blend_channel(t00[15:8], t10[15:8], t01[15:8], t11[15:8], fx, fy);
    res.blue  = blend_channel(t00[23:16], t10[23:16], t01[23:16], t11[23:16], fx, fy);
    res.alpha = blend_channel(t00[31:24], t10[31:24], t01[31:24], t11[31:24], fx, fy);
    return res;
  endfunction

  task automatic check_channel(input string name, input logic [bts_pkg::OUT_W-1:0] want,
                               input logic [bts_pkg::OUT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    filtered_t want;
    if (!rst_n) begin
      width_reg  = bts_pkg::SIZE_RESET;
      height_reg = bts_pkg::SIZE_RESET;
      mismatches = 0;
      filtered_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == bts_pkg::CFG_IMAGE_WIDTH) begin
          width_reg = cfg_data;
        end else if (cfg_index == bts_pkg::CFG_IMAGE_HEIGHT) begin
          height_reg = cfg_data;
        end
      end
      if (out_valid) begin
        if (filtered_q.size() == 0) begin
          $error("result strobed with no sample outstanding");
          mismatches++;
        end else begin
          want = filtered_q.pop_front();
          check_channel("out_red", want.red, out_red);
          check_channel("out_green", want.green, out_green);
          check_channel("out_blue", want.blue, out_blue);
          check_channel("out_alpha", want.alpha, out_alpha);
        end
      end
      // Results leave only after their request has passed the pipeline, so a sample
      // pushed here is never the one popped above.
      if (start && !busy) begin
        if (in_mode == bts_pkg::MODE_WRITE) begin
          texture[in_texel_addr] = {in_texel_alpha, in_texel_blue, in_texel_green,
                                    in_texel_red};
        end else begin
          filtered_q.push_back(bilinear_filter(in_u_coord, in_v_coord));
        end
      end
    end
    samples_in_flight = filtered_q.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

// Top of the sampler regression. This module only creates stimulus and gives
// the verdict; all prediction and comparison lives in sampler_checker.
module testbench;
  import bts_pkg::*;

  localparam int SIDE_MAX     = 256;
  localparam int RUN_ITEMS    = 1350;
  // Samples are waited for by their count in flight; these cycles of margin
  // cover writes that are still on their way into the texel memory.
  localparam int DRAIN_CYCLES = 8;
  // Watchdog limit, far beyond the length of the slowest correct run.
  localparam int CYCLE_LIMIT  = 200000;

  // Register indexes that decode to nothing; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_B = 2'd3;

  localparam logic signed [COORD_W-1:0] COORD_MOST_NEG = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] COORD_MOST_POS = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_ONE      = COORD_W'(65536);

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic                        in_mode;
  logic [ADDR_W-1:0]           in_texel_addr;
  logic [CH_W-1:0]             in_texel_red;
  logic [CH_W-1:0]             in_texel_green;
  logic [CH_W-1:0]             in_texel_blue;
  logic [CH_W-1:0]             in_texel_alpha;
  logic signed [COORD_W-1:0]   in_u_coord;
  logic signed [COORD_W-1:0]   in_v_coord;
  logic                        out_valid;
  logic [OUT_W-1:0]            out_red;
  logic [OUT_W-1:0]            out_green;
  logic [OUT_W-1:0]            out_blue;
  logic [OUT_W-1:0]            out_alpha;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [CFG_W-1:0]            cfg_data;

  int mismatches;
  int samples_in_flight;

  // Stimulus bookkeeping. The texel memory powers up undefined, so every
  // address a sample will touch is written before that sample is sent. The
  // written map remembers which addresses hold data across size changes.
  bit                 written [0:65535];
  logic [CFG_W-1:0]   cur_w;
  logic [CFG_W-1:0]   cur_h;
  int                 issued;
  int                 idle_pct;
  int                 cycle_count = 0;

  bilinear_texture_sampler #(
    .MAX_WIDTH  (SIDE_MAX),
    .MAX_HEIGHT (SIDE_MAX)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_texel_addr  (in_texel_addr),
    .in_texel_red   (in_texel_red),
    .in_texel_green (in_texel_green),
    .in_texel_blue  (in_texel_blue),
    .in_texel_alpha (in_texel_alpha),
    .in_u_coord     (in_u_coord),
    .in_v_coord     (in_v_coord),
    .out_valid      (out_valid),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_alpha      (out_alpha),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  sampler_checker #(
    .MAX_WIDTH  (SIDE_MAX),
    .MAX_HEIGHT (SIDE_MAX)
  ) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_texel_addr     (in_texel_addr),
    .in_texel_red      (in_texel_red),
    .in_texel_green    (in_texel_green),
    .in_texel_blue     (in_texel_blue),
    .in_texel_alpha    (in_texel_alpha),
    .in_u_coord        (in_u_coord),
    .in_v_coord        (in_v_coord),
    .out_valid         (out_valid),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_alpha         (out_alpha),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatches        (mismatches),
    .samples_in_flight (samples_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Size as the block uses it: zero reads as one, anything above the
  // maximum saturates to the maximum.
  function automatic int unsigned fit_size(input logic [CFG_W-1:0] size_reg);
    if (size_reg == '0) begin
      return 1;
    end
    return (size_reg > SIDE_MAX) ? SIDE_MAX : size_reg;
  endfunction

  function automatic int unsigned unit_coord(input logic signed [COORD_W-1:0] c);
    if (c < 0) begin
      return 0;
    end
    return (c > 65536) ? 65536 : c;
  endfunction

  // Coordinates are mostly inside 0..1.0, with some anywhere in the signed
  // range and some pinned to the edges of the field and of the clamp.
  function automatic logic signed [COORD_W-1:0] random_coord();
    case ($urandom_range(9))
      0: return COORD_W'($urandom());
      1: begin
        case ($urandom_range(5))
          0: return COORD_MOST_NEG;
          1: return COORD_MOST_POS;
          2: return '0;
          3: return COORD_ONE;
          4: return COORD_ONE - 1;
          default: return -1;
        endcase
      end
      default: return COORD_W'($urandom_range(65536));
    endcase
  endfunction

  // One request on the input channel. Before it the sender may idle for a
  // random number of cycles; start stays high between back-to-back requests.
  task automatic issue(input mode_t mode, input logic [ADDR_W-1:0] addr,
                       input texel_t color, input logic signed [COORD_W-1:0] u,
                       input logic signed [COORD_W-1:0] v);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start          <= 1'b1;
    in_mode        <= mode;
    in_texel_addr  <= addr;
    {in_texel_alpha, in_texel_blue, in_texel_green, in_texel_red} <= color;
    in_u_coord     <= u;
    in_v_coord     <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    issued++;
    if (mode == MODE_WRITE) begin
      written[addr] = 1'b1;
    end
  endtask

  // Coordinates of a write request are don't-care, so they carry noise.
  task automatic write_texel(input logic [ADDR_W-1:0] addr, input texel_t color);
    issue(MODE_WRITE, addr, color, random_coord(), random_coord());
  endtask

  // A sample request, preceded by writes for any of its four neighbors that
  // never received data. The address and color fields of a sample are noise.
  task automatic sample(input logic signed [COORD_W-1:0] u,
                        input logic signed [COORD_W-1:0] v);
    int unsigned w, h, x0, y0, x1, y1;
    logic [ADDR_W-1:0] corner [4];
    w = fit_size(cur_w);
    h = fit_size(cur_h);
    x0 = (unit_coord(u) * (w - 1)) >> 16;
    y0 = (unit_coord(v) * (h - 1)) >> 16;
    x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
    y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
    corner[0] = ADDR_W'(x0 + y0 * w);
    corner[1] = ADDR_W'(x1 + y0 * w);
    corner[2] = ADDR_W'(x0 + y1 * w);
    corner[3] = ADDR_W'(x1 + y1 * w);
    foreach (corner[k]) begin
      if (!written[corner[k]]) begin
        write_texel(corner[k], $urandom());
      end
    end
    issue(MODE_SAMPLE, ADDR_W'($urandom()), $urandom(), u, v);
  endtask

  // Register writes happen only while the block is idle. Valid drops for a
  // cycle after each write so that it never falls and rises in one step.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    if (idx == CFG_IMAGE_WIDTH) begin
      cur_w = data;
    end else if (idx == CFG_IMAGE_HEIGHT) begin
      cur_h = data;
    end
  endtask

  // Hold the input channel off until every outstanding sample has returned,
  // then give trailing writes time to land in the texel memory.
  task automatic settle();
    start <= 1'b0;
    while (samples_in_flight != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One texture size and a batch of random traffic on it: texel writes inside
  // the image, writes anywhere in the memory, and samples whose footprints
  // always land on written texels. Now and then the sender drains fully.
  task automatic run_phase(input logic [CFG_W-1:0] w_cfg, input logic [CFG_W-1:0] h_cfg,
                           input int n_items);
    int          stop_at;
    int          pick;
    int unsigned w, h;
    settle();
    write_register(CFG_IMAGE_WIDTH, w_cfg);
    write_register(CFG_IMAGE_HEIGHT, h_cfg);
    if ($urandom_range(2) == 0) begin
      write_register($urandom_range(1) ? CFG_UNMAPPED_A : CFG_UNMAPPED_B, CFG_W'($urandom()));
    end
    w = fit_size(cur_w);
    h = fit_size(cur_h);
    stop_at = issued + n_items;
    while (issued < stop_at) begin
      pick = $urandom_range(199);
      if (pick == 0) begin
        settle();
      end else if (pick < 40) begin
        write_texel(ADDR_W'($urandom_range(w - 1) + $urandom_range(h - 1) * w), $urandom());
      end else if (pick < 60) begin
        write_texel(ADDR_W'($urandom()), $urandom());
      end else begin
        sample(random_coord(), random_coord());
      end
    end
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] w_rand, h_rand;
    // Every input is known from time zero, while reset is still held.
    rst_n          = 1'b0;
    start          = 1'b0;
    in_mode        = MODE_WRITE;
    in_texel_addr  = '0;
    in_texel_red   = '0;
    in_texel_green = '0;
    in_texel_blue  = '0;
    in_texel_alpha = '0;
    in_u_coord     = '0;
    in_v_coord     = '0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_IMAGE_WIDTH;
    cfg_data       = '0;
    cur_w          = SIZE_RESET;
    cur_h          = SIZE_RESET;
    issued         = 0;
    idle_pct       = 36;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, on the reset size of 256 by 256. The first 2x2 block
    // holds full-scale and zero texels so that the output reaches its top
    // value and the fractional blend mixes the extremes.
    write_texel(16'd0, {4{8'hFF}});
    write_texel(16'd1, '0);
    write_texel(16'd256, {8'hFF, 8'h00, 8'hFF, 8'h00});
    write_texel(16'd257, {8'h00, 8'hFF, 8'h00, 8'hFF});
    sample('0, '0);
    sample(COORD_W'(128), COORD_W'(128));
    // Exactly 1.0 lands on the last texel, whose neighbors clamp onto itself.
    write_texel(16'hFFFF, {4{8'hFF}});
    sample(COORD_ONE, COORD_ONE);
    // Coordinates beyond either end of the clamp range, and one pair inside it.
    sample(COORD_MOST_POS, COORD_MOST_NEG);
    sample(-1, COORD_ONE + 1);
    sample(COORD_ONE - 1, COORD_W'(257));

    // Unmapped register indexes, with all-ones and all-zeros data.
    settle();
    write_register(CFG_UNMAPPED_A, '1);
    write_register(CFG_UNMAPPED_B, '0);

    // Size extremes: zero reads as one texel, 511 saturates to the maximum,
    // single rows and columns, and the smallest true 2D image.
    run_phase(9'd0, 9'd0, 40);
    run_phase(9'd511, 9'd511, 60);
    run_phase(9'd256, 9'd1, 60);
    run_phase(9'd1, 9'd256, 60);
    run_phase(9'd1, 9'd1, 30);
    run_phase(9'd2, 9'd2, 40);

    // A long stretch where the sender never idles between requests, apart from drains.
    idle_pct = 0;
    run_phase(9'd4, 9'd4, 200);
    idle_pct = 36;

    // Random sizes, mostly small so that footprints quickly hit written
    // texels, and now and then anything the register can hold.
    while (issued < RUN_ITEMS) begin
      case ($urandom_range(9))
        0: begin
          w_rand = CFG_W'($urandom_range(511));
          h_rand = CFG_W'($urandom_range(511));
        end
        1, 2: begin
          w_rand = CFG_W'($urandom_range(64, 17));
          h_rand = CFG_W'($urandom_range(64, 17));
        end
        default: begin
          w_rand = CFG_W'($urandom_range(16, 1));
          h_rand = CFG_W'($urandom_range(16, 1));
        end
      endcase
      run_phase(w_rand, h_rand, $urandom_range(80, 40));
    end

    // Wait for the last results and the tail of the pipeline, then judge.
    settle();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
